// ===== rtl/core/wifi_ie_security_parser_top_macros.svh =====
// Assertion macros used by the information-element parser RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef WIFI_IE_SECURITY_PARSER_TOP_MACROS_SVH
`define WIFI_IE_SECURITY_PARSER_TOP_MACROS_SVH

// Same-cycle implication, skipped while reset is low.
`define WISP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is low.
`define WISP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wisp_pkg.sv =====
// Package for the information-element security parser: codes, suites and types.
// No dependencies; used by all modules of the block except wisp_ram.
`default_nettype none

package wisp_pkg;

  localparam logic [7:0]  KIND_SSID   = 8'd0;
  localparam logic [7:0]  KIND_RSN    = 8'd48;
  localparam logic [7:0]  KIND_VENDOR = 8'd221;

  localparam logic [31:0] SUITE_TKIP  = 32'h000F_AC02;
  localparam logic [31:0] SUITE_CCMP  = 32'h000F_AC04;
  localparam logic [31:0] VENDOR_WPA  = 32'h0050_F201;
  localparam logic [31:0] VENDOR_WPS  = 32'h0050_F204;

  localparam logic [15:0] RSN_VER_ONE = 16'h0001;

  // Security flag bit positions
  localparam int FL_PAIR_TKIP  = 0;
  localparam int FL_PAIR_CCMP  = 1;
  localparam int FL_PSK        = 2;
  localparam int FL_GROUP_TKIP = 3;
  localparam int FL_GROUP_CCMP = 4;
  localparam int FL_WPA        = 5;
  localparam int FL_WPS        = 6;

  localparam int FLAG_W   = 7;
  localparam int SLEN_W   = 6;
  localparam int SIDX_W   = 5;
  localparam int STORE_AW = 6;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    EM_PARSE,
    EM_READ,
    EM_LOAD
  } emit_state_t;

  // SSID store write port
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } ssid_wr_t;

  // Committed view after the current byte, before the per-blob clear
  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [SLEN_W-1:0] len;
    logic              bank;
  } parse_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/wisp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module wisp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wisp_parse.sv =====
// Record walker: type/length/payload tracking, RSN and vendor decode, SSID capture.
// Depends on wisp_pkg; drives the SSID store write port.
`default_nettype none

module wisp_parse #(
  parameter int SSID_CAP = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  acc,
  input  wire logic [7:0]            blob_byte,
  input  wire logic                  blob_end,
  output wisp_pkg::ssid_wr_t         wr,
  output wisp_pkg::parse_stat_t      stat
);

  wisp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  rlen_r, rlen_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic        ver_ok_r, ver_ok_nxt;
  logic [18:0] pw_end_r, pw_end_nxt;
  logic [19:0] akm_end_r, akm_end_nxt;
  logic [6:0]  pflags_r, pflags_nxt;
  logic [6:0]  cflags_r, cflags_nxt;
  logic        bank_r, bank_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic [5:0]  clen_r, clen_nxt;

  logic        commit;
  logic [15:0] le;
  logic [7:0]  off_inc;
  logic [19:0] off_w;

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    rlen_nxt    = rlen_r;
    off_nxt     = off_r;
    shift_nxt   = shift_r;
    ver_ok_nxt  = ver_ok_r;
    pw_end_nxt  = pw_end_r;
    akm_end_nxt = akm_end_r;
    pflags_nxt  = pflags_r;
    cflags_nxt  = cflags_r;
    bank_nxt    = bank_r;
    plen_nxt    = plen_r;
    clen_nxt    = clen_r;
    wr          = '0;
    commit      = 1'b0;
    le          = {blob_byte, shift_r[7:0]};
    off_inc     = off_r + 8'd1;
    off_w       = {12'd0, off_r};

    if (acc) begin
      case (phase_r)
        wisp_pkg::PH_LEN: begin
          rlen_nxt    = blob_byte;
          off_nxt     = 8'd0;
          shift_nxt   = 32'd0;
          ver_ok_nxt  = 1'b0;
          pw_end_nxt  = 19'd8;
          akm_end_nxt = 20'd0;
          pflags_nxt  = 7'd0;
          plen_nxt    = 6'd0;
          phase_nxt   = wisp_pkg::PH_BODY;
          if (blob_byte == 8'd0) begin
            commit = 1'b1;
          end
        end
        wisp_pkg::PH_BODY: begin
          shift_nxt = {shift_r[23:0], blob_byte};
          off_nxt   = off_inc;
          if (kind_r == wisp_pkg::KIND_SSID) begin
            if (off_r < 8'(SSID_CAP)) begin
              wr.en   = 1'b1;
              wr.addr = {~bank_r, off_r[4:0]};
              wr.data = blob_byte;
              if (blob_byte != 8'd0) begin
                plen_nxt = off_r[5:0] + 6'd1;
              end
            end
          end else if (kind_r == wisp_pkg::KIND_RSN) begin
            if (off_r == 8'd1) begin
              ver_ok_nxt = (le == wisp_pkg::RSN_VER_ONE);
            end else if (off_r > 8'd1 && ver_ok_r) begin
              if (off_r == 8'd5) begin
                if (shift_nxt == wisp_pkg::SUITE_TKIP) begin
                  pflags_nxt[wisp_pkg::FL_GROUP_TKIP] = 1'b1;
                end else if (shift_nxt == wisp_pkg::SUITE_CCMP) begin
                  pflags_nxt[wisp_pkg::FL_GROUP_CCMP] = 1'b1;
                end
              end else if (off_r == 8'd7) begin
                pw_end_nxt = 19'd8 + {1'b0, le, 2'b00};
              end else if (off_r >= 8'd8) begin
                // Pairwise suites are 4-byte aligned from offset 8 and end at offset
                // 3 mod 4; AKM suites end at 1 mod 4.
                if (off_w < {1'b0, pw_end_r}) begin
                  if (off_r[1:0] == 2'd3) begin
                    if (shift_nxt == wisp_pkg::SUITE_TKIP) begin
                      pflags_nxt[wisp_pkg::FL_PAIR_TKIP] = 1'b1;
                    end else if (shift_nxt == wisp_pkg::SUITE_CCMP) begin
                      pflags_nxt[wisp_pkg::FL_PAIR_CCMP] = 1'b1;
                    end
                  end
                end else if (off_w == {1'b0, pw_end_r} + 20'd1) begin
                  akm_end_nxt = {1'b0, pw_end_r} + 20'd2 + {2'b00, le, 2'b00};
                end else if (off_w >= {1'b0, pw_end_r} + 20'd2 && off_w < akm_end_r) begin
                  if (off_r[1:0] == 2'd1 && shift_nxt == wisp_pkg::SUITE_TKIP) begin
                    pflags_nxt[wisp_pkg::FL_PSK] = 1'b1;
                  end
                end
              end
            end
          end else if (kind_r == wisp_pkg::KIND_VENDOR) begin
            if (off_r == 8'd3) begin
              if (shift_nxt == wisp_pkg::VENDOR_WPA) begin
                pflags_nxt[wisp_pkg::FL_WPA] = 1'b1;
              end else if (shift_nxt == wisp_pkg::VENDOR_WPS) begin
                pflags_nxt[wisp_pkg::FL_WPS] = 1'b1;
              end
            end
          end
          if (off_inc == rlen_r) begin
            commit = 1'b1;
          end
        end
        default: begin
          kind_nxt  = blob_byte;
          phase_nxt = wisp_pkg::PH_LEN;
        end
      endcase
    end

    // Record complete: publish its effects
    if (commit) begin
      phase_nxt = wisp_pkg::PH_TYPE;
      if (kind_r == wisp_pkg::KIND_SSID) begin
        clen_nxt = plen_nxt;
        bank_nxt = ~bank_r;
      end else if (kind_r inside {wisp_pkg::KIND_RSN, wisp_pkg::KIND_VENDOR}) begin
        cflags_nxt = cflags_r | pflags_nxt;
      end
    end

    stat.flags = cflags_nxt;
    stat.len   = clen_nxt;
    stat.bank  = bank_nxt;

    // Drop any open record and start afresh; the bank choice carries over
    if (acc && blob_end) begin
      phase_nxt   = wisp_pkg::PH_TYPE;
      kind_nxt    = 8'd0;
      rlen_nxt    = 8'd0;
      off_nxt     = 8'd0;
      shift_nxt   = 32'd0;
      ver_ok_nxt  = 1'b0;
      pw_end_nxt  = 19'd8;
      akm_end_nxt = 20'd0;
      pflags_nxt  = 7'd0;
      cflags_nxt  = 7'd0;
      plen_nxt    = 6'd0;
      clen_nxt    = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wisp_pkg::PH_TYPE;
      kind_r    <= 8'd0;
      rlen_r    <= 8'd0;
      off_r     <= 8'd0;
      shift_r   <= 32'd0;
      ver_ok_r  <= 1'b0;
      pw_end_r  <= 19'd8;
      akm_end_r <= 20'd0;
      pflags_r  <= 7'd0;
      cflags_r  <= 7'd0;
      bank_r    <= 1'b0;
      plen_r    <= 6'd0;
      clen_r    <= 6'd0;
    end else begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      rlen_r    <= rlen_nxt;
      off_r     <= off_nxt;
      shift_r   <= shift_nxt;
      ver_ok_r  <= ver_ok_nxt;
      pw_end_r  <= pw_end_nxt;
      akm_end_r <= akm_end_nxt;
      pflags_r  <= pflags_nxt;
      cflags_r  <= cflags_nxt;
      bank_r    <= bank_nxt;
      plen_r    <= plen_nxt;
      clen_r    <= clen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wisp_emit.sv =====
// Result sequencer: snapshots flags and SSID length at blob end, reads the store.
// Depends on wisp_pkg and the assertion macro header.
`default_nettype none
`include "wifi_ie_security_parser_top_macros.svh"

module wisp_emit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire wisp_pkg::parse_stat_t stat,
  output logic                       busy,
  output logic                       rd_en,
  output logic [wisp_pkg::STORE_AW-1:0] rd_addr,
  input  wire logic [7:0]            rd_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [wisp_pkg::FLAG_W-1:0] out_flags,
  output logic [wisp_pkg::SLEN_W-1:0] out_len,
  output logic [wisp_pkg::SIDX_W-1:0] out_idx,
  output logic [7:0]                 out_char,
  output logic                       out_last
);

  wisp_pkg::emit_state_t state_r, state_nxt;
  logic [wisp_pkg::SIDX_W-1:0] idx_r, idx_nxt;
  logic [wisp_pkg::FLAG_W-1:0] flags_s_r, flags_s_nxt;
  logic [wisp_pkg::SLEN_W-1:0] len_s_r, len_s_nxt;
  logic                        bank_s_r, bank_s_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [wisp_pkg::FLAG_W-1:0] out_flags_r;
  logic [wisp_pkg::SLEN_W-1:0] out_len_r;
  logic [wisp_pkg::SIDX_W-1:0] out_idx_r;
  logic [7:0]                  out_char_r;
  logic                        out_last_r;

  logic load;
  logic is_last;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    flags_s_nxt   = flags_s_r;
    len_s_nxt     = len_s_r;
    bank_s_nxt    = bank_s_r;
    rd_en         = 1'b0;
    rd_addr       = {bank_s_r, idx_r};
    load          = 1'b0;
    is_last       = (len_s_r == '0) ||
                    (6'(idx_r) + 6'd1 == len_s_r);
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      wisp_pkg::EM_PARSE: begin
        if (start) begin
          flags_s_nxt = stat.flags;
          len_s_nxt   = stat.len;
          bank_s_nxt  = stat.bank;
          idx_nxt     = '0;
          state_nxt   = wisp_pkg::EM_READ;
        end
      end
      wisp_pkg::EM_READ: begin
        rd_en     = 1'b1;
        state_nxt = wisp_pkg::EM_LOAD;
      end
      wisp_pkg::EM_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          if (is_last) begin
            state_nxt = wisp_pkg::EM_PARSE;
          end else begin
            idx_nxt   = idx_r + 5'd1;
            state_nxt = wisp_pkg::EM_READ;
          end
        end
      end
      default: begin
        state_nxt = wisp_pkg::EM_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wisp_pkg::EM_PARSE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r     <= idx_nxt;
    flags_s_r <= flags_s_nxt;
    len_s_r   <= len_s_nxt;
    bank_s_r  <= bank_s_nxt;
    if (load) begin
      out_flags_r <= flags_s_r;
      out_len_r   <= len_s_r;
      out_idx_r   <= idx_r;
      out_char_r  <= (len_s_r == '0) ? 8'd0 : rd_data;
      out_last_r  <= is_last;
    end
  end

  assign busy      = (state_r != wisp_pkg::EM_PARSE);
  assign out_valid = out_valid_r;
  assign out_flags = out_flags_r;
  assign out_len   = out_len_r;
  assign out_idx   = out_idx_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `WISP_ASSERT_NXT(a_start_reads, start && state_r == wisp_pkg::EM_PARSE,
    state_r == wisp_pkg::EM_READ, "blob end did not start a store read")
  `WISP_ASSERT_NXT(a_read_then_load, state_r == wisp_pkg::EM_READ,
    state_r == wisp_pkg::EM_LOAD, "store read not followed by load")
  `WISP_ASSERT_IMP(a_idx_in_range, state_r == wisp_pkg::EM_LOAD,
    len_s_r == '0 || 6'(idx_r) < len_s_r, "SSID index beyond snapshot length")
  `WISP_ASSERT_IMP(a_last_index, out_valid_r && out_last_r && out_len_r != '0,
    6'(out_idx_r) + 6'd1 == out_len_r, "run_last not on final SSID byte")

endmodule

`default_nettype wire

// ===== rtl/core/wifi_ie_security_parser_top.sv =====
// Information-element security parser: accepts one blob byte per cycle while the
// result sequencer is idle; on the final byte it replays one result per SSID byte
// (one result for an empty SSID), each by a store read, then an output load, and
// holds the input stalled until the last result is loaded. Synchronous active-low
// reset clears all parse and sequencer control; the SSID store is not cleared.
`default_nettype none

module wifi_ie_security_parser_top #(
  parameter int SSID_BYTES = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // blob byte input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_blob_byte,
  input  wire logic       in_blob_end,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_sec_flags,
  output logic [5:0]      out_ssid_length,
  output logic [4:0]      out_ssid_index,
  output logic [7:0]      out_ssid_char,
  output logic            out_run_last
);

  // SSID bytes kept per record: the parameter, never beyond one 32-byte bank
  localparam int SSID_CAP = (SSID_BYTES < 32) ? SSID_BYTES : 32;

  logic                   in_xfer;
  logic                   emit_busy;
  wisp_pkg::ssid_wr_t     ssid_wr;
  wisp_pkg::parse_stat_t  parse_stat;
  logic                   rd_en;
  logic [wisp_pkg::STORE_AW-1:0] rd_addr;
  logic [7:0]             rd_data;

  // A byte transfers when valid while the sequencer is not replaying an SSID
  assign in_stall = emit_busy;
  assign in_xfer  = in_valid && !in_stall;

  // Record walker: tracks phase, decodes RSN and vendor records, and writes
  // SSID payload into the bank not currently committed.
  wisp_parse #(
    .SSID_CAP (SSID_CAP)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_xfer),
    .blob_byte (in_blob_byte),
    .blob_end  (in_blob_end),
    .wr        (ssid_wr),
    .stat      (parse_stat)
  );

  // Two banks of 32 SSID bytes; a completed SSID record flips the live bank.
  wisp_ram #(
    .WIDTH (8),
    .DEPTH (64)
  ) u_ssid_store (
    .clk   (clk),
    .we    (ssid_wr.en),
    .waddr (ssid_wr.addr),
    .wdata (ssid_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Result sequencer: snapshot at blob end, then one transfer per SSID byte
  // (or a single transfer for an empty SSID) through a registered output.
  wisp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer && in_blob_end),
    .stat      (parse_stat),
    .busy      (emit_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_flags (out_sec_flags),
    .out_len   (out_ssid_length),
    .out_idx   (out_ssid_index),
    .out_char  (out_ssid_char),
    .out_last  (out_run_last)
  );

endmodule

`default_nettype wire

// ===== bench/tb_ie_scan_pkg.sv =====
// Scoreboard for the information-element security parser bench: a byte-level
// predictor of flags and SSID plus the queue of SSID results still owed.
// Depends on wisp_pkg for record kinds, suites, flag positions and phase codes.
package tb_ie_scan_pkg;
  import wisp_pkg::*;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [SLEN_W-1:0] len;
    logic [SIDX_W-1:0] idx;
    logic [7:0]        ch;
    logic              last;
  } ssid_result_t;

  localparam int MAX_REPORTS = 100;

  class beacon_scan_checker;
    int unsigned  ssid_cap;
    phase_t       phase;
    logic [7:0]   kind, rec_len, offset;
    logic [31:0]  field_acc, group_suite;
    logic [15:0]  rsn_ver, pair_cnt, akm_cnt;
    logic [6:0]   pend_flags, comm_flags;
    logic [7:0]   ssid_mem [64];
    logic         bank;
    logic [5:0]   pend_slen, comm_slen;
    ssid_result_t ssid_results_due[$];
    int unsigned  errors;

    function new(int unsigned ssid_bytes);
      ssid_cap = (ssid_bytes < 32) ? ssid_bytes : 32;
      errors = 0;
      bank = 1'b0;
      foreach (ssid_mem[i]) ssid_mem[i] = 8'h00;
      clear_blob();
    endfunction

    function void clear_blob();
      phase = PH_TYPE;
      kind = '0;
      rec_len = '0;
      offset = '0;
      field_acc = '0;
      group_suite = '0;
      rsn_ver = '0;
      pair_cnt = '0;
      akm_cnt = '0;
      pend_flags = '0;
      comm_flags = '0;
      pend_slen = '0;
      comm_slen = '0;
    endfunction

    function void commit_record();
      if (kind == KIND_SSID) begin
        comm_slen = pend_slen;
        bank = ~bank;
      end else if (kind == KIND_RSN || kind == KIND_VENDOR) begin
        comm_flags = comm_flags | pend_flags;
      end
      phase = PH_TYPE;
    endfunction

    function void start_record(logic [7:0] len);
      rec_len = len;
      offset = '0;
      field_acc = '0;
      group_suite = '0;
      rsn_ver = '0;
      pair_cnt = '0;
      akm_cnt = '0;
      pend_flags = '0;
      pend_slen = '0;
      phase = PH_BODY;
      if (len == 8'd0) commit_record();
    endfunction

    function void take_payload(logic [7:0] b);
      int unsigned o, a;
      logic [15:0] le;
      o = offset;
      field_acc = {field_acc[23:0], b};
      // two-byte fields arrive little-endian
      le = {field_acc[7:0], field_acc[15:8]};
      case (kind)
        KIND_SSID: begin
          if (o < ssid_cap) begin
            // write into the bank that is not on display
            ssid_mem[(bank ? 0 : 32) + (o & 31)] = b;
            if (b != 8'h00) pend_slen = 6'(o + 1);
          end
        end
        KIND_RSN: begin
          if (o == 1) begin
            rsn_ver = le;
          end else if (o > 1 && rsn_ver == RSN_VER_ONE) begin
            if (o == 5) begin
              group_suite = field_acc;
              if (group_suite == SUITE_TKIP) pend_flags[FL_GROUP_TKIP] = 1'b1;
              else if (group_suite == SUITE_CCMP) pend_flags[FL_GROUP_CCMP] = 1'b1;
            end else if (o == 7) begin
              pair_cnt = le;
            end else if (o >= 8) begin
              a = 8 + 4 * int'(pair_cnt);
              if (o < a) begin
                if (((o - 8) & 3) == 3) begin
                  if (field_acc == SUITE_TKIP) pend_flags[FL_PAIR_TKIP] = 1'b1;
                  else if (field_acc == SUITE_CCMP) pend_flags[FL_PAIR_CCMP] = 1'b1;
                end
              end else if (o == a + 1) begin
                akm_cnt = le;
              end else if (o >= a + 2 && o < a + 2 + 4 * int'(akm_cnt)) begin
                if (((o - a - 2) & 3) == 3 && field_acc == SUITE_TKIP)
                  pend_flags[FL_PSK] = 1'b1;
              end
            end
          end
        end
        KIND_VENDOR: begin
          if (o == 3) begin
            if (field_acc == VENDOR_WPA) pend_flags[FL_WPA] = 1'b1;
            else if (field_acc == VENDOR_WPS) pend_flags[FL_WPS] = 1'b1;
          end
        end
        default: ;
      endcase
      offset = 8'(o + 1);
      if (offset == rec_len) commit_record();
    endfunction

    // Advance the predictor by one accepted blob byte; queue results on the final byte.
    function void note_byte(logic [7:0] b, logic last);
      int unsigned n;
      ssid_result_t r;
      case (phase)
        PH_LEN:  start_record(b);
        PH_BODY: take_payload(b);
        default: begin
          kind = b;
          phase = PH_LEN;
        end
      endcase
      if (last) begin
        n = (comm_slen > ssid_cap) ? ssid_cap : comm_slen;
        r.flags = comm_flags;
        if (n == 0) begin
          r.len = '0;
          r.idx = '0;
          r.ch = '0;
          r.last = 1'b1;
          ssid_results_due.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.len = 6'(n);
            r.idx = 5'(i);
            r.ch = ssid_mem[(bank ? 32 : 0) + i];
            r.last = (i + 1 == n);
            ssid_results_due.push_back(r);
          end
        end
        clear_blob();
      end
    endfunction

    function void compare_field(longint unsigned stamp, string what,
                                int unsigned want, int unsigned got);
      if (want == got) return;
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0d ns: %s mismatch, expected 0x%0h, got 0x%0h", stamp, what, want, got);
    endfunction

    function void check_ssid_result(longint unsigned stamp, logic [6:0] flags,
                                    logic [5:0] len, logic [4:0] idx,
                                    logic [7:0] ch, logic last);
      ssid_result_t want;
      if (ssid_results_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0d ns: unexpected result, expected none, got flags 0x%0h len %0d idx %0d char 0x%0h last %0b",
                   stamp, flags, len, idx, ch, last);
        return;
      end
      want = ssid_results_due.pop_front();
      compare_field(stamp, "sec_flags", want.flags, flags);
      compare_field(stamp, "ssid_length", want.len, len);
      compare_field(stamp, "ssid_index", want.idx, idx);
      compare_field(stamp, "ssid_char", want.ch, ch);
      compare_field(stamp, "run_last", want.last, last);
    endfunction

    function int unsigned outstanding();
      return ssid_results_due.size();
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for wifi_ie_security_parser_top: drives beacon IE blobs one byte
// per transfer, with random gaps and result back-pressure, and checks every result.
// Depends on wisp_pkg and tb_ie_scan_pkg; needs no files or arguments.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wisp_pkg::*;
  import tb_ie_scan_pkg::*;

  localparam int SSID_BYTES   = 32;
  localparam int RANDOM_BYTES = 480;
  // worst case per blob: 32 results, each waiting out a receiver stall plus a store
  // read and output load; each long hold adds a LONG_HOLD stretch of back-pressure
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 400;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_blob_byte;
  logic       in_blob_end;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] out_sec_flags;
  logic [5:0] out_ssid_length;
  logic [4:0] out_ssid_index;
  logic [7:0] out_ssid_char;
  logic       out_run_last;

  // shared between the sender and the result sink
  logic quiet;          // no idling on either side for the current blob
  logic long_hold_req;  // ask the sink for one long back-pressure stretch

  int unsigned cycles;
  logic [7:0]  blob_q[$];
  logic [7:0]  rec_body[$];

  beacon_scan_checker scan_chk;

  wifi_ie_security_parser_top #(
    .SSID_BYTES(SSID_BYTES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_blob_byte(in_blob_byte),
    .in_blob_end(in_blob_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sec_flags(out_sec_flags),
    .out_ssid_length(out_ssid_length),
    .out_ssid_index(out_ssid_index),
    .out_ssid_char(out_ssid_char),
    .out_run_last(out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sample the result channel at the rising edge; a transfer is valid with no stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      scan_chk.check_ssid_result($time, out_sec_flags, out_ssid_length, out_ssid_index,
                                 out_ssid_char, out_run_last);
  end

  // Result sink: before each transfer hold stall high for a random count of cycles,
  // or for one long stretch when asked, then release it until a transfer happens.
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 3);
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Drive blob_q one byte per transfer, blob_end on its final byte. Change inputs at
  // the falling edge only, and hold them while stalled.
  task automatic send_blob();
    int unsigned gap;
    logic        last;
    foreach (blob_q[i]) begin
      last = (i == blob_q.size() - 1);
      gap = quiet ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      @(negedge clk);
      in_valid     <= 1'b1;
      in_blob_byte <= blob_q[i];
      in_blob_end  <= last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      scan_chk.note_byte(blob_q[i], last);
    end
  endtask

  function automatic void push_suite(logic [31:0] s);
    rec_body.push_back(s[31:24]);
    rec_body.push_back(s[23:16]);
    rec_body.push_back(s[15:8]);
    rec_body.push_back(s[7:0]);
  endfunction

  function automatic void push_le16(logic [15:0] v);
    rec_body.push_back(v[7:0]);
    rec_body.push_back(v[15:8]);
  endfunction

  function automatic logic [31:0] pick_suite();
    case ($urandom_range(0, 3))
      0: return SUITE_TKIP;
      1: return SUITE_CCMP;
      2: return {SUITE_CCMP[31:8], 8'($urandom_range(0, 7))};
      default: return $urandom;
    endcase
  endfunction

  // Append one record to blob_q. Mostly well-formed SSID, RSN and vendor records
  // with random content; some are cut short or carry counts past the payload.
  // Returns the record's total size in bytes.
  function automatic int unsigned add_record();
    logic [7:0]  kind;
    int unsigned pick, n, zc, pc, ac;
    rec_body.delete();
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      kind = KIND_SSID;
      if ($urandom_range(0, 19) == 0) n = $urandom_range(33, 255);
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(28, 40);
      else n = $urandom_range(0, 12);
      // trailing zeros get stripped from the length; stray zeros inside stay
      zc = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < n; i++)
        rec_body.push_back((i + zc >= n || $urandom_range(0, 7) == 0) ?
                           8'h00 : 8'($urandom_range(1, 255)));
    end else if (pick < 6) begin
      kind = KIND_RSN;
      push_le16(($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : RSN_VER_ONE);
      push_suite(pick_suite());
      pc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
      push_le16(16'(pc));
      for (int k = 0; k < pc && k < 3; k++) push_suite(pick_suite());
      ac = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
      push_le16(16'(ac));
      for (int k = 0; k < ac && k < 3; k++) push_suite(pick_suite());
      if ($urandom_range(0, 1) == 0) push_le16(16'($urandom_range(0, 65535)));
      // truncate: fields and suites past the payload end must not count
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(0, rec_body.size())) void'(rec_body.pop_back());
    end else if (pick < 8) begin
      kind = KIND_VENDOR;
      if ($urandom_range(0, 3) == 0) push_suite($urandom);
      else
        push_suite({VENDOR_WPA[31:8], ($urandom_range(0, 2) == 0) ?
                    8'($urandom_range(0, 255)) :
                    (($urandom_range(0, 1) == 0) ? VENDOR_WPA[7:0] : VENDOR_WPS[7:0])});
      repeat ($urandom_range(0, 4)) rec_body.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, rec_body.size())) void'(rec_body.pop_back());
    end else begin
      kind = 8'($urandom_range(0, 255));
      repeat ($urandom_range(0, 6)) rec_body.push_back(8'($urandom_range(0, 255)));
    end
    blob_q.push_back(kind);
    blob_q.push_back(8'(rec_body.size()));
    foreach (rec_body[i]) blob_q.push_back(rec_body[i]);
    return rec_body.size() + 2;
  endfunction

  initial begin : stimulus
    int unsigned sent, blobs, last_size;
    in_valid      = 1'b0;
    in_blob_byte  = 8'h00;
    in_blob_end   = 1'b0;
    out_stall     = 1'b0;
    rst_n         = 1'b0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    cycles        = 0;
    scan_chk = new(SSID_BYTES);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Lone type byte on the final byte: the open record is dropped, SSID is empty.
    blob_q = {8'hFF};
    send_blob();
    // Zero-length SSID, then an SSID with trailing zeros, then a WPS vendor record.
    blob_q = {KIND_SSID, 8'd0, KIND_SSID, 8'd3, 8'h41, 8'h00, 8'h00,
              KIND_VENDOR, 8'd4, VENDOR_WPS[31:24], VENDOR_WPS[23:16],
              VENDOR_WPS[15:8], VENDOR_WPS[7:0]};
    send_blob();
    // Short RSN record: version 1 and a CCMP group suite, no pairwise list.
    blob_q = {KIND_RSN, 8'd6, RSN_VER_ONE[7:0], RSN_VER_ONE[15:8],
              SUITE_CCMP[31:24], SUITE_CCMP[23:16], SUITE_CCMP[15:8], SUITE_CCMP[7:0]};
    send_blob();
    // SSID record that overruns the blob end.
    blob_q = {KIND_SSID, 8'd5, 8'h7F};
    send_blob();

    sent = 0;
    blobs = 0;
    while (sent < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 7) == 0);
      // back-pressure long enough that the result sequencer holds and stalls the input
      if (blobs == 15 || blobs == 60) long_hold_req = 1'b1;
      blob_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        // noise: raw bytes with no structure
        repeat ($urandom_range(1, 12)) blob_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) last_size = add_record();
        // leave the final record open: its effects must vanish
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, last_size - 1)) void'(blob_q.pop_back());
      end
      sent += blob_q.size();
      send_blob();
      blobs++;
    end
    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;

    // Drain: wait for every owed result, then watch for strays a while longer.
    while (scan_chk.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (scan_chk.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
